FILE: rtl/aptt_pkg.sv
// ----------------------------------------------------------------------------
// aptt_pkg
// Shared widths, codes and reset constants of the adaptive poll timeout
// tracker.
// ----------------------------------------------------------------------------
package aptt_pkg;

    // Field widths
    localparam int TS_W      = 48;   // timestamps, intervals, averages
    localparam int TIMEOUT_W = 42;   // timeout in microseconds
    localparam int CFG_W     = 32;   // limit registers, milliseconds
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 1;

    // Shared divider: divisor width and digits retired per cycle
    localparam int DIVISOR_W     = 12;
    localparam int DIV_RADIX_W   = 4;
    localparam int SCALE_DIVISOR = 4000;  // quarter of whole milliseconds

    // Command codes
    localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POLL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIMITS = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TIMEOUT = 1'b1;

    // Reset values
    localparam logic [CFG_W-1:0]     MIN_RESET_MS = 32'd5000;
    localparam logic [CFG_W-1:0]     MAX_RESET_MS = 32'd60000;
    localparam logic [TIMEOUT_W-1:0] RESET_LO_US  = 42'd5000000;

endpackage

FILE: rtl/adaptive_poll_timeout_tracker_core.sv
// ----------------------------------------------------------------------------
// adaptive_poll_timeout_tracker_core
// Start, limits-changed and unused codes: after acceptance the limits are ordered, the
// command executes and the result is loaded. Poll: the history is summed, divided for
// the mean and, unless the mean is below the minimum, divided again for the scaling,
// both on the shared 4-bit-per-cycle divider.
// One transaction in flight; the next can be taken in the cycle after the result is loaded,
// and a result held by a stalled consumer holds the sequencer.
// Reset: limits 5000/60000 ms, history seeded with 5000000 us, fill and head 1.
// ----------------------------------------------------------------------------
module adaptive_poll_timeout_tracker_core #(
    parameter int HISTORY_DEPTH = 5
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_write_en,
    input  logic [aptt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [aptt_pkg::CFG_W-1:0]     cfg_data,
    // command channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [aptt_pkg::CMD_W-1:0]     command,
    input  logic [aptt_pkg::TS_W-1:0]      timestamp_us,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [aptt_pkg::TIMEOUT_W-1:0] current_timeout_us,
    output logic [aptt_pkg::TS_W-1:0]      average_interval_us,
    output logic [aptt_pkg::TS_W-1:0]      last_interval_us,
    output logic                           abnormal
);
    import aptt_pkg::*;

    // Ring indexing and the widths that follow from the history depth
    localparam int HEAD_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = TS_W + $clog2(HISTORY_DEPTH);
    localparam logic [HEAD_W-1:0] START_HEAD = HEAD_W'(1 % HISTORY_DEPTH);
    localparam logic [HEAD_W-1:0] LAST_SLOT  = HEAD_W'(HISTORY_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LIMITS,
        S_EXEC,
        S_SUM,
        S_AVG_GO,
        S_AVG_WAIT,
        S_CHECK,
        S_SCALE_GO,
        S_SCALE_WAIT,
        S_ADD,
        S_CAP,
        S_RESULT
    } state_t;

    // Milliseconds to microseconds: x*1024 - x*16 - x*8
    function automatic logic [TIMEOUT_W-1:0] ms_to_us(input logic [CFG_W-1:0] ms);
        logic [TIMEOUT_W-1:0] x;
        x = TIMEOUT_W'(ms);
        return (x << 10) - (x << 4) - (x << 3);
    endfunction

    // Control and history state
    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    min_ms_reg, max_ms_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [TS_W-1:0]     ts_reg;
    logic [TS_W-1:0]     last_poll_reg, last_poll_next;
    logic [TS_W-1:0]     ring_reg [HISTORY_DEPTH];
    logic [TS_W-1:0]     ring_next [HISTORY_DEPTH];
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [HEAD_W-1:0]   head_reg, head_next;
    logic [HEAD_W-1:0]   idx_reg, idx_next;
    logic [TIMEOUT_W-1:0] timeout_reg, timeout_next;
    logic [TS_W-1:0]     avg_reg, avg_next;
    logic [TS_W-1:0]     last_int_reg, last_int_next;
    logic                out_valid_reg, out_valid_next;

    // Working registers of one transaction
    logic [TIMEOUT_W-1:0] lo_reg, hi_reg;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [TS_W-1:0]      scaled_reg, scaled_next;
    logic [TS_W:0]        tsum_reg, tsum_next;
    logic                 load_out;

    // Shared divider hookup
    logic                 div_start;
    logic [SUM_W-1:0]     div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic                 div_done;
    logic [SUM_W-1:0]     div_quot;

    logic                 accept;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    aptt_div #(
        .DIVIDEND_W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // The divider serves the history mean first, then the quarter scaling of the mean
    always_comb
    begin
        div_start    = (state_reg == S_AVG_GO) || (state_reg == S_SCALE_GO);
        div_dividend = sum_reg;
        div_divisor  = DIVISOR_W'(fill_reg);
        if (state_reg == S_SCALE_GO)
        begin
            div_dividend = SUM_W'(avg_reg);
            div_divisor  = DIVISOR_W'(SCALE_DIVISOR);
        end
    end

    // Sequencer
    always_comb
    begin
        logic [TS_W-1:0] dur;
        logic [TS_W-1:0] q;

        state_next     = state_reg;
        last_poll_next = last_poll_reg;
        ring_next      = ring_reg;
        fill_next      = fill_reg;
        head_next      = head_reg;
        idx_next       = idx_reg;
        timeout_next   = timeout_reg;
        avg_next       = avg_reg;
        last_int_next  = last_int_reg;
        sum_next       = sum_reg;
        scaled_next    = scaled_reg;
        tsum_next      = tsum_reg;
        out_valid_next = out_valid_reg;
        load_out       = 1'b0;

        // A backwards timestamp saturates the interval to zero
        dur = (ts_reg >= last_poll_reg) ? (ts_reg - last_poll_reg) : '0;
        q   = div_quot[TS_W-1:0];

        // Drop the result once the consumer takes it
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_LIMITS;
            end
            S_LIMITS:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                case (cmd_reg)
                    CMD_START:
                    begin
                        for (int i = 0; i < HISTORY_DEPTH; i++)
                            ring_next[i] = '0;
                        ring_next[0]   = TS_W'(lo_reg);
                        fill_next      = FILL_W'(1);
                        head_next      = START_HEAD;
                        timeout_next   = lo_reg;
                        avg_next       = TS_W'(lo_reg);
                        last_int_next  = TS_W'(lo_reg);
                        last_poll_next = ts_reg;
                        state_next     = S_RESULT;
                    end
                    CMD_POLL:
                    begin
                        ring_next[head_reg] = dur;
                        last_int_next       = dur;
                        head_next = (head_reg == LAST_SLOT) ? '0 : head_reg + HEAD_W'(1);
                        if (fill_reg < FILL_W'(HISTORY_DEPTH))
                            fill_next = fill_reg + FILL_W'(1);
                        last_poll_next = ts_reg;
                        idx_next       = '0;
                        sum_next       = '0;
                        state_next     = S_SUM;
                    end
                    CMD_LIMITS:
                    begin
                        if (timeout_reg < lo_reg)
                            timeout_next = lo_reg;
                        else if (timeout_reg > hi_reg)
                            timeout_next = hi_reg;
                        state_next = S_RESULT;
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_SUM:
            begin
                sum_next = sum_reg + SUM_W'(ring_reg[idx_reg]);
                idx_next = idx_reg + HEAD_W'(1);
                if (idx_reg == LAST_SLOT)
                    state_next = S_AVG_GO;
            end
            S_AVG_GO:
            begin
                state_next = S_AVG_WAIT;
            end
            S_AVG_WAIT:
            begin
                if (div_done)
                begin
                    avg_next   = q;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (avg_reg < TS_W'(lo_reg))
                begin
                    timeout_next = lo_reg;
                    state_next   = S_RESULT;
                end
                else
                begin
                    state_next = S_SCALE_GO;
                end
            end
            S_SCALE_GO:
            begin
                state_next = S_SCALE_WAIT;
            end
            S_SCALE_WAIT:
            begin
                if (div_done)
                begin
                    // whole quarters back to microseconds: q*1000
                    scaled_next = (q << 10) - (q << 4) - (q << 3);
                    state_next  = S_ADD;
                end
            end
            S_ADD:
            begin
                tsum_next  = {1'b0, avg_reg} + {1'b0, scaled_reg};
                state_next = S_CAP;
            end
            S_CAP:
            begin
                if (tsum_reg > (TS_W + 1)'(hi_reg))
                    timeout_next = hi_reg;
                else
                    timeout_next = tsum_reg[TIMEOUT_W-1:0];
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, limit registers, history and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            min_ms_reg    <= MIN_RESET_MS;
            max_ms_reg    <= MAX_RESET_MS;
            last_poll_reg <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
                ring_reg[i] <= (i == 0) ? TS_W'(RESET_LO_US) : '0;
            fill_reg      <= FILL_W'(1);
            head_reg      <= START_HEAD;
            idx_reg       <= '0;
            timeout_reg   <= RESET_LO_US;
            avg_reg       <= TS_W'(RESET_LO_US);
            last_int_reg  <= TS_W'(RESET_LO_US);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_MIN_TIMEOUT: min_ms_reg <= cfg_data;
                    REG_MAX_TIMEOUT: max_ms_reg <= cfg_data;
                    default:         ;
                endcase
            end
            last_poll_reg <= last_poll_next;
            ring_reg      <= ring_next;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
            idx_reg       <= idx_next;
            timeout_reg   <= timeout_next;
            avg_reg       <= avg_next;
            last_int_reg  <= last_int_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Transaction working registers and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            ts_reg  <= timestamp_us;
        end
        // Order the limit pair and scale it to microseconds
        if (state_reg == S_LIMITS)
        begin
            lo_reg <= ms_to_us((min_ms_reg < max_ms_reg) ? min_ms_reg : max_ms_reg);
            hi_reg <= ms_to_us((min_ms_reg > max_ms_reg) ? min_ms_reg : max_ms_reg);
        end
        sum_reg    <= sum_next;
        scaled_reg <= scaled_next;
        tsum_reg   <= tsum_next;
        if (load_out)
        begin
            current_timeout_us  <= timeout_reg;
            average_interval_us <= avg_reg;
            last_interval_us    <= last_int_reg;
            abnormal            <= (avg_reg > TS_W'(timeout_reg));
        end
    end

    assign out_valid = out_valid_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg >= FILL_W'(1)) && (fill_reg <= FILL_W'(HISTORY_DEPTH)))
        else $error("history fill count out of range");

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= LAST_SLOT)
        else $error("ring head beyond the last slot");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_LIMITS))
        else $error("accepted command did not start the sequencer");

    a_timeout_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RESULT)
         && ((cmd_reg == CMD_START) || (cmd_reg == CMD_POLL) || (cmd_reg == CMD_LIMITS)))
        |-> ((timeout_reg >= lo_reg) && (timeout_reg <= hi_reg)))
        else $error("timeout outside the limits after a command");

endmodule

FILE: rtl/aptt_div.sv
// ----------------------------------------------------------------------------
// aptt_div
// Iterative restoring divider with a narrow divisor; retires DIV_RADIX_W
// quotient bits per cycle.
// ----------------------------------------------------------------------------
module aptt_div #(
    parameter int DIVIDEND_W = 51
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [DIVIDEND_W-1:0]          dividend,
    input  logic [aptt_pkg::DIVISOR_W-1:0] divisor,
    output logic                           done,
    output logic [DIVIDEND_W-1:0]          quotient
);
    import aptt_pkg::*;

    localparam int STEPS = (DIVIDEND_W + DIV_RADIX_W - 1) / DIV_RADIX_W;
    localparam int DIV_W = STEPS * DIV_RADIX_W;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_W-1:0]     quot_reg;
    logic [DIV_W-1:0]     quot_next;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] rem_next;
    logic [DIVISOR_W-1:0] divisor_reg;

    // Shift in DIV_RADIX_W dividend bits, restoring subtract for each
    always_comb
    begin
        logic [DIV_W-1:0]   q_v;
        logic [DIVISOR_W:0] r_v;
        q_v = quot_reg;
        r_v = {1'b0, rem_reg};
        for (int k = 0; k < DIV_RADIX_W; k++)
        begin
            r_v = {r_v[DIVISOR_W-1:0], q_v[DIV_W-1]};
            q_v = {q_v[DIV_W-2:0], 1'b0};
            if (r_v >= {1'b0, divisor_reg})
            begin
                r_v    = r_v - {1'b0, divisor_reg};
                q_v[0] = 1'b1;
            end
        end
        quot_next = q_v;
        rem_next  = r_v[DIVISOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(STEPS - 1))
                    busy_reg <= 1'b0;
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg    <= DIV_W'(dividend);
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg[DIVIDEND_W-1:0];

endmodule

FILE: test/tb_adaptive_poll_timeout_tracker_core.sv
// ----------------------------------------------------------------------------
// tb_adaptive_poll_timeout_tracker_core
// Self-checking regression of the adaptive poll timeout tracker. A
// behavioural predictor of the interval history and the timeout rule works
// out the result of every accepted command. A monitor compares each result,
// field by field, with the oldest outstanding prediction. Directed checks
// cover reset state, ring wrap, timestamp extremes and limit extremes.
// Random phases then run start/poll sequences under a range of limit
// settings, with bursty command traffic and a stalling result consumer.
// ----------------------------------------------------------------------------
module tb_adaptive_poll_timeout_tracker_core;
    timeunit 1ns;
    timeprecision 1ps;

    import aptt_pkg::*;

    localparam int HISTORY_DEPTH = 5;
    // Code 3 has no meaning to the tracker: it must leave the state alone
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 212;
    // Allow for a poll to finish after the last result
    localparam int SETTLE_CYCLES = 60;
    // Slowest run: every command a poll, longest sender gap and consumer
    // stall on each, for ~1750 items, taken several times over
    localparam int CYCLE_LIMIT   = 800000;

    // One result as the tracker reports it
    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout;
        logic [TS_W-1:0]      average;
        logic [TS_W-1:0]      last;
        logic                 abnormal;
    } tracker_report_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [CMD_W-1:0]     command;
    logic [TS_W-1:0]      timestamp_us;
    logic                 out_valid;
    logic                 out_stall;
    logic [TIMEOUT_W-1:0] current_timeout_us;
    logic [TS_W-1:0]      average_interval_us;
    logic [TS_W-1:0]      last_interval_us;
    logic                 abnormal;

    // Predicted copy of the tracker state and its limit registers
    logic [CFG_W-1:0]     limit_a_ms;
    logic [CFG_W-1:0]     limit_b_ms;
    logic [TS_W-1:0]      prev_poll_us;
    logic [TS_W-1:0]      interval_hist [HISTORY_DEPTH];
    logic [2:0]           hist_fill;
    logic [2:0]           hist_head;
    logic [TIMEOUT_W-1:0] timeout_in_force;
    logic [TS_W-1:0]      mean_interval;

    tracker_report_t      expected_reports [$];
    int                   fault_count;
    int                   cycle_count;
    int                   burst_left;
    bit                   idle_enabled;

    adaptive_poll_timeout_tracker_core #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write_en        (cfg_write_en),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .command             (command),
        .timestamp_us        (timestamp_us),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .current_timeout_us  (current_timeout_us),
        .average_interval_us (average_interval_us),
        .last_interval_us    (last_interval_us),
        .abnormal            (abnormal)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // The smaller register is the minimum, the larger the maximum, in us
    function automatic logic [TIMEOUT_W-1:0] lower_limit_us();
        logic [CFG_W-1:0] pick;
        pick = (limit_a_ms < limit_b_ms) ? limit_a_ms : limit_b_ms;
        return TIMEOUT_W'(64'(pick) * 64'd1000);
    endfunction

    function automatic logic [TIMEOUT_W-1:0] upper_limit_us();
        logic [CFG_W-1:0] pick;
        pick = (limit_a_ms > limit_b_ms) ? limit_a_ms : limit_b_ms;
        return TIMEOUT_W'(64'(pick) * 64'd1000);
    endfunction

    // Clear the history and seed its first slot with the minimum
    task automatic seed_intervals(input logic [TS_W-1:0] ts);
        logic [TIMEOUT_W-1:0] floor_us;
        floor_us = lower_limit_us();
        foreach (interval_hist[i])
            interval_hist[i] = '0;
        interval_hist[0] = TS_W'(floor_us);
        hist_fill        = 3'd1;
        hist_head        = 3'(1 % HISTORY_DEPTH);
        timeout_in_force = floor_us;
        mean_interval    = TS_W'(floor_us);
        prev_poll_us     = ts;
    endtask

    // Advance the predicted state by one accepted transaction and queue the
    // result that it must produce
    task automatic track_command(input logic [CMD_W-1:0] cmd, input logic [TS_W-1:0] ts);
        logic [TIMEOUT_W-1:0] floor_us;
        logic [TIMEOUT_W-1:0] ceiling_us;
        logic [TS_W-1:0]      span;
        logic [50:0]          total;
        logic [63:0]          grown;
        tracker_report_t      report;
        floor_us   = lower_limit_us();
        ceiling_us = upper_limit_us();
        case (cmd)
            CMD_START:
                seed_intervals(ts);
            CMD_POLL:
            begin
                // a timestamp that runs backwards gives a zero interval
                span = (ts >= prev_poll_us) ? ts - prev_poll_us : '0;
                interval_hist[hist_head] = span;
                hist_head = 3'((hist_head + 1) % HISTORY_DEPTH);
                if (hist_fill < HISTORY_DEPTH)
                    hist_fill = hist_fill + 3'd1;
                total = '0;
                foreach (interval_hist[i])
                    total = total + 51'(interval_hist[i]);
                mean_interval = TS_W'(total / 51'(hist_fill));
                prev_poll_us  = ts;
                if (mean_interval < floor_us)
                    timeout_in_force = floor_us;
                else
                begin
                    grown = 64'(mean_interval) + 64'(mean_interval / 4000) * 64'd1000;
                    timeout_in_force = (grown > 64'(ceiling_us)) ? ceiling_us
                                                                 : TIMEOUT_W'(grown);
                end
            end
            CMD_LIMITS:
            begin
                if (timeout_in_force < floor_us)
                    timeout_in_force = floor_us;
                if (timeout_in_force > ceiling_us)
                    timeout_in_force = ceiling_us;
            end
            default:
                ;
        endcase
        report.timeout  = timeout_in_force;
        report.average  = mean_interval;
        report.last     = interval_hist[3'((hist_head + HISTORY_DEPTH - 1) % HISTORY_DEPTH)];
        report.abnormal = (mean_interval > timeout_in_force);
        expected_reports.insert(expected_reports.size(), report);
    endtask

    // ------------------------------------------------------------------------
    // Result monitor: compare each accepted transaction with the oldest
    // outstanding prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        tracker_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("result with no command outstanding: timeout %0d average %0d",
                       current_timeout_us, average_interval_us);
                fault_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                if (current_timeout_us !== want.timeout)
                begin
                    $error("current_timeout_us: expected %0d, got %0d",
                           want.timeout, current_timeout_us);
                    fault_count++;
                end
                if (average_interval_us !== want.average)
                begin
                    $error("average_interval_us: expected %0d, got %0d",
                           want.average, average_interval_us);
                    fault_count++;
                end
                if (last_interval_us !== want.last)
                begin
                    $error("last_interval_us: expected %0d, got %0d",
                           want.last, last_interval_us);
                    fault_count++;
                end
                if (abnormal !== want.abnormal)
                begin
                    $error("abnormal: expected %0b, got %0b", want.abnormal, abnormal);
                    fault_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result consumer: stall on a pattern that is redrawn after each random span -
    // none, coin toss, periodic bursts, or mostly stalled
    // ------------------------------------------------------------------------
    initial
    begin : stall_pattern
        int mode;
        int span;
        int tick;
        out_stall = 1'b0;
        tick      = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 300);
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 1) == 1);
                    2:       out_stall <= ((tick % 11) < 4);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command driver. Every task is entered and left at a falling edge.
    // ------------------------------------------------------------------------

    // Send one command. The sender works in bursts; between bursts, if gaps are
    // enabled, it drops valid for a random gap. Valid is left high on return so that a
    // back-to-back transaction follows without a bubble.
    task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [TS_W-1:0] ts);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (idle_enabled)
                gap = $urandom_range(0, 12);
        end
        burst_left--;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        timestamp_us <= ts;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_command(cmd, ts);
        @(negedge clk);
    endtask

    // Drop valid and wait until every outstanding result has arrived; the
    // tracker holds one transaction at a time, so it is idle after that
    task automatic drain_results;
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    // Write both limit registers; only call while the tracker is idle
    task automatic set_limits(input logic [CFG_W-1:0] first_ms,
                              input logic [CFG_W-1:0] second_ms);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_MIN_TIMEOUT;
        cfg_data     <= first_ms;
        @(negedge clk);
        cfg_index    <= REG_MAX_TIMEOUT;
        cfg_data     <= second_ms;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        limit_a_ms = first_ms;
        limit_b_ms = second_ms;
    endtask

    function automatic logic [TS_W-1:0] random_stamp();
        return TS_W'({$urandom, $urandom});
    endfunction

    // Interval between polls: tiny, in the range of typical limits,
    // 32-bit, or any magnitude up to the full timestamp width
    function automatic logic [TS_W-1:0] random_interval();
        case ($urandom_range(0, 3))
            0:       return TS_W'($urandom_range(0, 4000));
            1:       return TS_W'($urandom_range(0, 200000)) * TS_W'(1000);
            2:       return TS_W'($urandom);
            default: return TS_W'({$urandom, $urandom} >> $urandom_range(0, 47));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Report the seeded reset state, untouched by an unused code, then clamp
    task automatic test_reset_state;
        issue_command(CMD_UNUSED, random_stamp());
        issue_command(CMD_LIMITS, {TS_W{1'b1}});
        issue_command(CMD_UNUSED, '0);
        drain_results();
    endtask

    // Poll before any start, then start and poll past a full ring so the
    // oldest interval is overwritten; averages cross the minimum both ways
    task automatic test_start_and_poll;
        logic [TS_W-1:0] stamp;
        issue_command(CMD_POLL, TS_W'(3000000));
        issue_command(CMD_START, '0);
        issue_command(CMD_POLL, TS_W'(1000));
        stamp = TS_W'(1000);
        repeat (6)
        begin
            stamp = stamp + TS_W'(20000000);
            issue_command(CMD_POLL, stamp);
        end
        issue_command(CMD_POLL, stamp + TS_W'(999));
        drain_results();
    endtask

    // Largest possible interval, a timestamp running backwards, a zero
    // interval at the top of the timestamp range
    task automatic test_timestamp_extremes;
        issue_command(CMD_START, '0);
        issue_command(CMD_POLL, {TS_W{1'b1}});
        issue_command(CMD_POLL, '0);
        issue_command(CMD_START, {TS_W{1'b1}});
        issue_command(CMD_POLL, {TS_W{1'b1}});
        drain_results();
    endtask

    // Zero limits, full-scale limits, a swapped pair, and a tiny maximum
    // that leaves the average above the timeout
    task automatic test_limit_extremes;
        set_limits('0, '0);
        issue_command(CMD_LIMITS, '0);
        issue_command(CMD_POLL, {TS_W{1'b1}});
        drain_results();
        set_limits({CFG_W{1'b1}}, {CFG_W{1'b1}});
        issue_command(CMD_LIMITS, '0);
        drain_results();
        set_limits(MAX_RESET_MS, MIN_RESET_MS);
        issue_command(CMD_LIMITS, '0);
        issue_command(CMD_START, TS_W'(100));
        issue_command(CMD_POLL, TS_W'(400000100));
        drain_results();
        set_limits(CFG_W'(1), CFG_W'(2));
        issue_command(CMD_LIMITS, '0);
        issue_command(CMD_POLL, TS_W'(900000100));
        drain_results();
    endtask

    // Random phases, each under its own limit setting. Most traffic is a
    // start followed by a run of polls with random spacing; the rest is
    // clamps, unused codes and polls at arbitrary times.
    task automatic test_random_traffic;
        int              sent;
        int              roll;
        int              run_len;
        logic [CFG_W-1:0] first_ms;
        logic [CFG_W-1:0] second_ms;
        logic [TS_W-1:0] clock_us;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: begin first_ms = MIN_RESET_MS; second_ms = MAX_RESET_MS; end
                1: begin first_ms = '0; second_ms = {CFG_W{1'b1}}; end
                2: begin first_ms = {CFG_W{1'b1}}; second_ms = '0; end
                3:
                begin
                    first_ms  = $urandom_range(0, 200000);
                    second_ms = $urandom_range(0, 200000);
                end
                4: begin first_ms = $urandom; second_ms = $urandom; end
                5: begin first_ms = $urandom_range(1, 100000); second_ms = first_ms; end
                6: begin first_ms = CFG_W'(1); second_ms = $urandom_range(1, 50); end
                default: begin first_ms = {CFG_W{1'b1}}; second_ms = {CFG_W{1'b1}}; end
            endcase
            set_limits(first_ms, second_ms);
            // keep one phase in three free of sender gaps
            idle_enabled = (phase % 3 != 1);
            issue_command(CMD_LIMITS, random_stamp());
            sent     = 1;
            clock_us = random_stamp();
            while (sent < PHASE_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 80)
                begin
                    issue_command(CMD_START, clock_us);
                    sent++;
                    run_len = $urandom_range(1, 14);
                    repeat (run_len)
                    begin
                        // now and then step the clock backwards
                        if ($urandom_range(0, 19) == 0)
                            clock_us = clock_us - TS_W'($urandom_range(1, 100000));
                        else
                            clock_us = clock_us + random_interval();
                        issue_command(CMD_POLL, clock_us);
                        sent++;
                    end
                end
                else if (roll < 88)
                begin
                    issue_command(CMD_LIMITS, random_stamp());
                    sent++;
                end
                else if (roll < 93)
                begin
                    issue_command(CMD_UNUSED, random_stamp());
                    sent++;
                end
                else
                begin
                    issue_command(CMD_POLL, random_stamp());
                    sent++;
                end
            end
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // Watchdog: end the run if it overstays the cycle budget
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("adaptive_poll_timeout_tracker_core regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = REG_MIN_TIMEOUT;
        cfg_data     = '0;
        in_valid     = 1'b0;
        command      = CMD_START;
        timestamp_us = '0;
        fault_count  = 0;
        burst_left   = 0;
        idle_enabled = 1'b1;
        limit_a_ms   = MIN_RESET_MS;
        limit_b_ms   = MAX_RESET_MS;
        seed_intervals('0);

        // hold reset, then release it away from the rising edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_start_and_poll();
        test_timestamp_extremes();
        test_limit_extremes();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0 && expected_reports.size() == 0)
            $display("adaptive_poll_timeout_tracker_core regression: pass");
        else
            $display("adaptive_poll_timeout_tracker_core regression: fail");
        $finish;
    end

endmodule
